FILE: rtl/core/acked_frame_link_handshake_unit_defines.svh
// Assertion macros used by the link engine RTL.
`ifndef ACKED_FRAME_LINK_HANDSHAKE_UNIT_DEFINES_SVH
`define ACKED_FRAME_LINK_HANDSHAKE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define AFL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("link engine assertion failed");

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define AFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("link engine assertion failed");

`endif

FILE: rtl/core/afl_pkg.sv
`timescale 1ns / 1ps

package afl_pkg;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_POLL    = 2'd1,
    OP_WRITE   = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  localparam logic [7:0] CTL_PING     = 8'h80;
  localparam logic [7:0] CTL_PING_ACK = 8'h81;
  localparam logic [7:0] CTL_START    = 8'h82;
  localparam logic [7:0] CTL_NEXT     = 8'h83;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
    logic [2:0] index;
    logic       commit;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       accepted;
    logic       peer_found;
    logic       frame_received;
    logic       send_pending;
  } rsp_t;

endpackage

FILE: rtl/core/acked_frame_link_handshake_unit.sv
// Link engine for a byte serial link that trades fixed frames with a peer.
// The request channel (in_valid_i, in_ready_o, in_req_i) carries one received
// byte, one poll tick, one local byte write or one peer byte read per request.
// The response channel (out_valid_o, out_ready_i, out_rsp_o) returns exactly
// one response per request: the byte to transmit, read data, the write status
// and the link flags as they stand after the request.
// The response is registered: a request accepted in one cycle shows its response
// in the next. Throughput is one request per cycle while responses are taken, set
// by the single output register; the engine state updates in the accept cycle.
// When the receiver stalls, the response register holds and in_ready_o drops
// until the response is taken; a new request is taken in the same cycle the
// held response leaves.
// Reset clears both frame buffers, the positions and all flags, and leaves the
// response channel empty. Only the first eight frame bytes are addressable by
// the host, so the buffers hold at most eight bytes.
module acked_frame_link_handshake_unit #(
  parameter int FRAME_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  afl_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output afl_pkg::rsp_t out_rsp_o
);

  import afl_pkg::*;

  localparam int PW = $clog2(FRAME_BYTES);
  localparam int BUF_DEPTH = (FRAME_BYTES < 8) ? FRAME_BYTES : 8;
  localparam int BW = $clog2(BUF_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

  logic          accept;
  logic [PW-1:0] tx_pos_q, tx_pos_d;
  logic [PW-1:0] rx_pos_q, rx_pos_d;
  logic          pend_q, pend_d;
  logic          recv_q, recv_d;
  logic          found_q, found_d;
  logic          out_valid_q;
  rsp_t          rsp_q, rsp_d;

  logic          idx_ok;
  logic          local_we, peer_we;
  logic [7:0]    local_rdata, peer_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign idx_ok     = 32'(in_req_i.index) < FRAME_BYTES;

  afl_frame_buf #(
    .DEPTH (BUF_DEPTH)
  ) u_local_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (local_we),
    .waddr_i (in_req_i.index[BW-1:0]),
    .wdata_i (in_req_i.byte_value),
    .raddr_i (tx_pos_q[BW-1:0]),
    .rdata_o (local_rdata)
  );

  afl_frame_buf #(
    .DEPTH (BUF_DEPTH)
  ) u_peer_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (peer_we),
    .waddr_i (rx_pos_q[BW-1:0]),
    .wdata_i (in_req_i.byte_value),
    .raddr_i (in_req_i.index[BW-1:0]),
    .rdata_o (peer_rdata)
  );

  always_comb begin
    tx_pos_d = tx_pos_q;
    rx_pos_d = rx_pos_q;
    pend_d   = pend_q;
    recv_d   = recv_q;
    found_d  = found_q;
    local_we = 1'b0;
    peer_we  = 1'b0;
    rsp_d    = '0;
    unique case (in_req_i.op)
      OP_RX_BYTE: begin
        priority if (in_req_i.byte_value == CTL_PING) begin
          found_d        = 1'b1;
          rsp_d.tx_valid = 1'b1;
          rsp_d.tx_byte  = CTL_PING_ACK;
        end else if (in_req_i.byte_value == CTL_PING_ACK) begin
          found_d = 1'b1;
        end else if (in_req_i.byte_value == CTL_START) begin
          rx_pos_d       = '0;
          recv_d         = 1'b0;
          rsp_d.tx_valid = 1'b1;
          rsp_d.tx_byte  = CTL_NEXT;
        end else if (in_req_i.byte_value == CTL_NEXT) begin
          if (pend_q) begin
            rsp_d.tx_valid = 1'b1;
            rsp_d.tx_byte  = (32'(tx_pos_q) < BUF_DEPTH) ? local_rdata : 8'h00;
            if (tx_pos_q == LAST_POS) begin
              tx_pos_d = '0;
              pend_d   = 1'b0;
            end else begin
              tx_pos_d = tx_pos_q + 1'b1;
            end
          end
        end else begin
          peer_we = accept && (32'(rx_pos_q) < BUF_DEPTH);
          if (rx_pos_q == LAST_POS) begin
            rx_pos_d = '0;
            recv_d   = 1'b1;
          end else begin
            rx_pos_d       = rx_pos_q + 1'b1;
            rsp_d.tx_valid = 1'b1;
            rsp_d.tx_byte  = CTL_NEXT;
          end
        end
      end
      OP_POLL: begin
        if (!found_q) begin
          rsp_d.tx_valid = 1'b1;
          rsp_d.tx_byte  = CTL_PING;
        end else if (pend_q) begin
          tx_pos_d       = '0;
          rsp_d.tx_valid = 1'b1;
          rsp_d.tx_byte  = CTL_START;
        end
      end
      OP_WRITE: begin
        if (!pend_q && idx_ok) begin
          local_we       = accept;
          rsp_d.accepted = 1'b1;
          if (in_req_i.commit) begin
            pend_d = 1'b1;
          end
        end
      end
      OP_READ: begin
        rsp_d.read_data = idx_ok ? peer_rdata : 8'h00;
        if (in_req_i.commit) begin
          recv_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
    rsp_d.peer_found     = found_d;
    rsp_d.frame_received = recv_d;
    rsp_d.send_pending   = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_pos_q    <= '0;
      rx_pos_q    <= '0;
      pend_q      <= 1'b0;
      recv_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tx_pos_q <= tx_pos_d;
        rx_pos_q <= rx_pos_d;
        pend_q   <= pend_d;
        recv_q   <= recv_d;
        found_q  <= found_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`include "acked_frame_link_handshake_unit_defines.svh"

  `AFL_ASSERT_NEXT(a_accept_gives_rsp, accept, out_valid_o)
  `AFL_ASSERT_NEXT(a_no_write_while_pending, accept && pend_q, !out_rsp_o.accepted)
  `AFL_ASSERT_NEXT(a_accepted_only_on_write, accept && (in_req_i.op != OP_WRITE),
                   !out_rsp_o.accepted)

endmodule

FILE: rtl/core/afl_frame_buf.sv
`timescale 1ns / 1ps

module afl_frame_buf #(
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        mem_q[i] <= 8'h00;
      end
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[raddr_i];

endmodule
